### sv/vfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video frame reassembler package
// Shared types and fixed constants of the frame reassembler.
// ----------------------------------------------------------------------------
package vfr_pkg;

  // Action codes of an input transaction.
  localparam logic [1:0] ACT_HEADER  = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_STATS   = 2'd2;

  // Reset value of the lag window register.
  localparam logic [15:0] WINDOW_RESET = 16'd200;

  // Saturation limits.
  localparam logic [23:0] LEN_MAX   = 24'hFFFFFF;
  localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] frame_no;
    logic [15:0] part_no;
    logic        is_last;
    logic [10:0] payload_size;
    logic        restored_by_fec;
    logic [1:0]  release_id;
  } item_t;

  typedef struct packed {
    logic        lost_partial;
    logic [15:0] lost_partial_parts;
    logic        abandoned_next;
    logic [30:0] lost_whole_frames;
    logic        accepted;
    logic [1:0]  buffer_id;
    logic [23:0] write_offset;
    logic        completed;
    logic        completed_fec;
    logic [31:0] discarded_count;
  } result_t;

  // Requests from the frame tracker to the buffer pool.
  typedef struct packed {
    logic push;
    logic pop;
  } pool_req_t;

  // Pool status as seen after this cycle's push.
  typedef struct packed {
    logic empty;
  } pool_sts_t;

endpackage

### sv/vfr_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video frame reassembler buffer pool
// Free stack of buffer ids with push-then-pop in a single cycle.
// ----------------------------------------------------------------------------
module vfr_pool #(
  parameter int POOL_BUFFERS = 3,
  parameter int IdW          = (POOL_BUFFERS > 1) ? $clog2(POOL_BUFFERS) : 1,
  parameter int CntW         = $clog2(POOL_BUFFERS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vfr_pkg::pool_req_t  req,
  input  logic [IdW-1:0]      push_id,
  output vfr_pkg::pool_sts_t  sts,
  output logic [IdW-1:0]      top_id
);

  logic [IdW-1:0]  stack_r [POOL_BUFFERS];
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic [CntW-1:0] count_a;
  logic [CntW-1:0] count_m1;
  logic            push_ok;
  logic            pop_ok;

  // A push onto a full stack is dropped; a pop sees the stack after the push.
  assign push_ok   = req.push && (count_r < CntW'(POOL_BUFFERS));
  assign count_a   = push_ok ? count_r + 1'b1 : count_r;
  assign count_m1  = count_r - 1'b1;
  assign sts.empty = (count_a == '0);
  assign top_id    = push_ok ? push_id : stack_r[count_m1[IdW-1:0]];
  assign pop_ok    = req.pop && !sts.empty;
  assign count_nxt = pop_ok ? count_a - 1'b1 : count_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CntW'(POOL_BUFFERS);
      for (int i = 0; i < POOL_BUFFERS; i++) begin
        stack_r[i] <= IdW'(i);
      end
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        stack_r[count_r[IdW-1:0]] <= push_id;
      end
    end
  end

endmodule

### sv/vfr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video frame reassembler core
// Frame and part tracking, resync, buffer hand-out and discard counting.
// ----------------------------------------------------------------------------
module vfr_core #(
  parameter int POOL_BUFFERS = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  vfr_pkg::item_t   item,
  input  logic [15:0]      window,
  output vfr_pkg::result_t res
);

  localparam int IdW = (POOL_BUFFERS > 1) ? $clog2(POOL_BUFFERS) : 1;

  logic [31:0]    cur_frame_r, cur_frame_nxt;
  logic [15:0]    next_part_r, next_part_nxt;
  logic           holding_r, holding_nxt;
  logic [IdW-1:0] held_buffer_r, held_buffer_nxt;
  logic           discard_r, discard_nxt;
  logic           fec_r, fec_nxt;
  logic [23:0]    frame_len_r, frame_len_nxt;
  logic [31:0]    discard_total_r, discard_total_nxt;

  vfr_pkg::pool_req_t pool_req;
  vfr_pkg::pool_sts_t pool_sts;
  logic [IdW-1:0]     pool_push_id;
  logic [IdW-1:0]     pool_top;

  logic        is_hdr, is_rel, is_stats;
  logic [31:0] lag_sum;
  logic [31:0] delta;
  logic        resync;
  logic [15:0] np_a;
  logic        holding_a, discard_a, fec_a;
  logic [23:0] len_a;
  logic        match;
  logic        take;
  logic        no_buffer;
  logic [IdW-1:0] buf_id;
  logic [23:0] offset;
  logic [24:0] sum;
  logic [23:0] sum_sat;
  logic        fec_n;

  vfr_pool #(.POOL_BUFFERS(POOL_BUFFERS)) u_pool (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (pool_req),
    .push_id (pool_push_id),
    .sts     (pool_sts),
    .top_id  (pool_top)
  );

  always_comb begin
    is_hdr   = (item.action == vfr_pkg::ACT_HEADER);
    is_rel   = (item.action == vfr_pkg::ACT_RELEASE);
    is_stats = (item.action == vfr_pkg::ACT_STATS);

    lag_sum = item.frame_no + {16'd0, window};
    delta   = item.frame_no - cur_frame_r;
    resync  = is_hdr && ((lag_sum < cur_frame_r) || (item.frame_no > cur_frame_r));

    np_a      = resync ? 16'd0 : next_part_r;
    holding_a = resync ? 1'b0  : holding_r;
    discard_a = resync ? 1'b0  : discard_r;
    fec_a     = resync ? 1'b0  : fec_r;
    len_a     = resync ? 24'd0 : frame_len_r;

    // After a resync the current frame equals the header's frame index.
    match = is_hdr && (resync || (item.frame_no == cur_frame_r)) &&
            (item.part_no == np_a) && !discard_a;
    no_buffer = match && !holding_a && pool_sts.empty;
    take      = match && !no_buffer;

    buf_id  = holding_a ? held_buffer_r : pool_top;
    offset  = holding_a ? len_a : 24'd0;
    sum     = {1'b0, offset} + {14'd0, item.payload_size};
    sum_sat = sum[24] ? vfr_pkg::LEN_MAX : sum[23:0];
    fec_n   = fec_a || item.restored_by_fec;

    // Pool traffic: a release, or a held buffer freed on resync, then a pop.
    pool_req.push = fire && ((is_rel && (32'(item.release_id) < POOL_BUFFERS)) ||
                             (resync && holding_r));
    pool_push_id  = is_rel ? IdW'(item.release_id) : held_buffer_r;
    pool_req.pop  = fire && match && !holding_a;

    // Result fields.
    res = '0;
    if (resync && (next_part_r != 16'd0)) begin
      res.lost_partial       = 1'b1;
      res.lost_partial_parts = next_part_r;
      res.abandoned_next     = (item.frame_no == cur_frame_r + 32'd1);
    end
    if (resync && (delta >= 32'd2) && !delta[31]) begin
      res.lost_whole_frames = delta[30:0] - 31'd1;
    end
    if (take) begin
      res.accepted      = 1'b1;
      res.buffer_id     = 2'(buf_id);
      res.write_offset  = offset;
      res.completed     = item.is_last;
      res.completed_fec = item.is_last && fec_n;
    end
    if (is_stats) begin
      res.discarded_count = discard_total_r;
    end

    // Next state.
    cur_frame_nxt     = resync ? item.frame_no : cur_frame_r;
    next_part_nxt     = np_a;
    holding_nxt       = holding_a;
    held_buffer_nxt   = held_buffer_r;
    discard_nxt       = discard_a;
    fec_nxt           = fec_a;
    frame_len_nxt     = len_a;
    discard_total_nxt = discard_total_r;

    if (is_stats) begin
      discard_total_nxt = 32'd0;
    end
    if (no_buffer) begin
      discard_nxt = 1'b1;
      if (discard_total_r != vfr_pkg::COUNT_MAX) begin
        discard_total_nxt = discard_total_r + 32'd1;
      end
    end
    if (take) begin
      if (item.is_last) begin
        holding_nxt   = 1'b0;
        next_part_nxt = 16'd0;
        fec_nxt       = 1'b0;
        discard_nxt   = 1'b0;
        frame_len_nxt = 24'd0;
      end else begin
        holding_nxt     = 1'b1;
        held_buffer_nxt = buf_id;
        next_part_nxt   = np_a + 16'd1;
        fec_nxt         = fec_n;
        frame_len_nxt   = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_frame_r     <= '0;
      next_part_r     <= '0;
      holding_r       <= 1'b0;
      held_buffer_r   <= '0;
      discard_r       <= 1'b0;
      fec_r           <= 1'b0;
      frame_len_r     <= '0;
      discard_total_r <= '0;
    end else if (fire) begin
      cur_frame_r     <= cur_frame_nxt;
      next_part_r     <= next_part_nxt;
      holding_r       <= holding_nxt;
      held_buffer_r   <= held_buffer_nxt;
      discard_r       <= discard_nxt;
      fec_r           <= fec_nxt;
      frame_len_r     <= frame_len_nxt;
      discard_total_r <= discard_total_nxt;
    end
  end

endmodule

### sv/video_frame_reassembler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video frame reassembler unit
// Tracks frame and part numbers of incoming packet headers, hands out frame
// buffers from a free pool and reports losses, completions and discards.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one transaction per
//   packet header, buffer release or statistics read. Every input
//   transaction produces exactly one result transaction on the output
//   channel (out_valid / out_stall), in order.
//   The block accepts one transaction per cycle while in_stall is low. A
//   transaction is captured in an input register, processed by the frame
//   tracker and buffer pool once the output register is free, and its
//   result is held in the output register, from which it can be taken.
//   Apart from receiver stalls, the rate is limited only by the state
//   update of the frame tracker.
//   When the receiver stalls, the output register holds its result and the
//   input register fills; in_stall rises only once both are occupied.
//   The cfg channel (cfg_valid / cfg_ready) writes the old frame window; it
//   is always ready and is meant to be written while the block is idle.
//   Synchronous reset clears the tracker, refills the pool with all buffer
//   ids (highest id handed out first) and sets the window to 200.
// ----------------------------------------------------------------------------
module video_frame_reassembler_unit #(
  parameter int POOL_BUFFERS = 3
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_frame_index,
  input  logic [15:0] in_part_index,
  input  logic        in_last_part,
  input  logic [10:0] in_payload_size,
  input  logic        in_restored_by_fec,
  input  logic [1:0]  in_release_id,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_lost_partial,
  output logic [15:0] out_lost_partial_parts,
  output logic        out_abandoned_next,
  output logic [30:0] out_lost_whole_frames,
  output logic        out_accepted,
  output logic [1:0]  out_buffer_id,
  output logic [23:0] out_write_offset,
  output logic        out_completed,
  output logic        out_completed_fec,
  output logic [31:0] out_discarded_count
);

  logic [15:0]      window_r;
  vfr_pkg::item_t   item_r;
  logic             item_valid_r, item_valid_nxt;
  vfr_pkg::result_t res;
  vfr_pkg::result_t res_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             fire;
  logic             in_take;

  // The output register frees when empty or when its transaction is taken.
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = item_valid_r && out_free;
  assign in_stall  = item_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_take) begin
      item_valid_nxt = 1'b1;
    end else if (fire) begin
      item_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      window_r     <= vfr_pkg::WINDOW_RESET;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_data;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action          <= in_action;
      item_r.frame_no        <= in_frame_index;
      item_r.part_no         <= in_part_index;
      item_r.is_last         <= in_last_part;
      item_r.payload_size    <= in_payload_size;
      item_r.restored_by_fec <= in_restored_by_fec;
      item_r.release_id      <= in_release_id;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  vfr_core #(.POOL_BUFFERS(POOL_BUFFERS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .window (window_r),
    .res    (res)
  );

  assign out_valid              = out_valid_r;
  assign out_lost_partial       = res_r.lost_partial;
  assign out_lost_partial_parts = res_r.lost_partial_parts;
  assign out_abandoned_next     = res_r.abandoned_next;
  assign out_lost_whole_frames  = res_r.lost_whole_frames;
  assign out_accepted           = res_r.accepted;
  assign out_buffer_id          = res_r.buffer_id;
  assign out_write_offset       = res_r.write_offset;
  assign out_completed          = res_r.completed;
  assign out_completed_fec      = res_r.completed_fec;
  assign out_discarded_count    = res_r.discarded_count;

endmodule

### sim/tb_video_frame_reassembler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video frame reassembler unit testbench
// Drives packet headers, buffer releases and statistics reads into the
// reassembler, predicts every result transaction with a behavioral copy of
// the frame tracker and buffer pool, and compares each result field by field.
// A directed table comes first, then random frame streams under several
// window settings and idle/stall phases.
// ----------------------------------------------------------------------------
module tb_video_frame_reassembler_unit;

  localparam int POOL = 3;
  localparam int CYCLE_LIMIT = 1000000;
  // Action code the block treats as a no-op.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [31:0] in_frame_index;
  logic [15:0] in_part_index;
  logic        in_last_part;
  logic [10:0] in_payload_size;
  logic        in_restored_by_fec;
  logic [1:0]  in_release_id;
  logic        out_valid;
  logic        out_stall;
  logic        out_lost_partial;
  logic [15:0] out_lost_partial_parts;
  logic        out_abandoned_next;
  logic [30:0] out_lost_whole_frames;
  logic        out_accepted;
  logic [1:0]  out_buffer_id;
  logic [23:0] out_write_offset;
  logic        out_completed;
  logic        out_completed_fec;
  logic [31:0] out_discarded_count;

  video_frame_reassembler_unit #(.POOL_BUFFERS(POOL)) i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_frame_index         (in_frame_index),
    .in_part_index          (in_part_index),
    .in_last_part           (in_last_part),
    .in_payload_size        (in_payload_size),
    .in_restored_by_fec     (in_restored_by_fec),
    .in_release_id          (in_release_id),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_lost_partial       (out_lost_partial),
    .out_lost_partial_parts (out_lost_partial_parts),
    .out_abandoned_next     (out_abandoned_next),
    .out_lost_whole_frames  (out_lost_whole_frames),
    .out_accepted           (out_accepted),
    .out_buffer_id          (out_buffer_id),
    .out_write_offset       (out_write_offset),
    .out_completed          (out_completed),
    .out_completed_fec      (out_completed_fec),
    .out_discarded_count    (out_discarded_count)
  );

  // One row of the directed table. When typed is set, res is the result
  // written down by hand; otherwise the tracker copy below supplies it.
  typedef struct {
    vfr_pkg::item_t   it;
    bit               typed;
    vfr_pkg::result_t res;
  } dir_row_t;

  // Expected results, oldest first, and bookkeeping for the summary.
  vfr_pkg::result_t pending_results[$];
  logic [1:0] finished_buffers[$];
  dir_row_t dir_rows[$];
  int errors;
  int n_sent;
  int n_checked;
  int n_frames_done;
  int cycle_cnt;
  int idle_pct;
  int stall_pct;

  // Behavioral copy of the frame tracker, the buffer pool and the window.
  logic [15:0] win_q;
  logic [31:0] trk_frame;
  logic [15:0] trk_part;
  bit          trk_holding;
  logic [1:0]  trk_buf;
  bit          trk_discard;
  bit          trk_fec;
  logic [23:0] trk_len;
  logic [31:0] discard_tot;
  logic [1:0]  free_ids [POOL];
  int          free_n;

  // State of the random frame stream that the sender is emitting.
  logic [31:0] gen_frame;
  logic [15:0] gen_part;
  int          gen_total;

  // Push a buffer id on the free stack; a full stack drops it.
  function automatic void pool_return(input logic [1:0] id);
    if (free_n < POOL) begin
      free_ids[free_n] = id;
      free_n++;
    end
  endfunction

  // Advance the tracker copy by one input transaction and return the result
  // that the block must produce for it.
  function automatic vfr_pkg::result_t frame_tracker_step(input vfr_pkg::item_t it);
    vfr_pkg::result_t r;
    logic [31:0] lag_sum;
    logic [31:0] frame_gap;
    logic [24:0] sum;
    bit          take;
    r = '0;
    case (it.action)
      vfr_pkg::ACT_RELEASE: begin
        if (it.release_id < POOL) pool_return(it.release_id);
      end
      vfr_pkg::ACT_STATS: begin
        r.discarded_count = discard_tot;
        discard_tot = '0;
      end
      vfr_pkg::ACT_HEADER: begin
        // A newer frame, or one lagging past the window, forces a resync.
        lag_sum = it.frame_no + {16'd0, win_q};
        if (lag_sum < trk_frame || it.frame_no > trk_frame) begin
          frame_gap = it.frame_no - trk_frame;
          if (trk_holding) begin
            pool_return(trk_buf);
            trk_holding = 1'b0;
          end
          trk_discard = 1'b0;
          if (trk_part != 16'd0) begin
            r.lost_partial = 1'b1;
            r.lost_partial_parts = trk_part;
            r.abandoned_next = (it.frame_no == trk_frame + 32'd1);
          end
          if (frame_gap >= 32'd2 && frame_gap <= 32'h7FFF_FFFF)
            r.lost_whole_frames = 31'(frame_gap - 32'd1);
          trk_frame = it.frame_no;
          trk_part = '0;
          trk_fec = 1'b0;
          trk_len = '0;
        end
        if (it.frame_no == trk_frame && it.part_no == trk_part && !trk_discard) begin
          take = 1'b1;
          if (!trk_holding) begin
            if (free_n == 0) begin
              // No buffer left: the whole frame is thrown away and counted.
              trk_discard = 1'b1;
              if (discard_tot != vfr_pkg::COUNT_MAX) discard_tot = discard_tot + 32'd1;
              take = 1'b0;
            end else begin
              free_n--;
              trk_buf = free_ids[free_n];
              trk_holding = 1'b1;
              trk_len = '0;
            end
          end
          if (take) begin
            trk_fec = trk_fec | it.restored_by_fec;
            trk_part = trk_part + 16'd1;
            r.accepted = 1'b1;
            r.buffer_id = trk_buf;
            r.write_offset = trk_len;
            sum = {1'b0, trk_len} + {14'd0, it.payload_size};
            trk_len = (sum > {1'b0, vfr_pkg::LEN_MAX}) ? vfr_pkg::LEN_MAX : sum[23:0];
            if (it.is_last) begin
              r.completed = 1'b1;
              r.completed_fec = trk_fec;
              trk_holding = 1'b0;
              trk_part = '0;
              trk_fec = 1'b0;
              trk_discard = 1'b0;
              trk_len = '0;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic vfr_pkg::item_t hdr(input logic [31:0] fi, input logic [15:0] pi,
                                         input bit lst, input logic [10:0] sz,
                                         input bit fec);
    vfr_pkg::item_t it;
    it = '0;
    it.action = vfr_pkg::ACT_HEADER;
    it.frame_no = fi;
    it.part_no = pi;
    it.is_last = lst;
    it.payload_size = sz;
    it.restored_by_fec = fec;
    return it;
  endfunction

  function automatic vfr_pkg::item_t ctl(input logic [1:0] act, input logic [1:0] id);
    vfr_pkg::item_t it;
    it = '0;
    it.action = act;
    it.release_id = id;
    return it;
  endfunction

  function automatic vfr_pkg::result_t acc_res(input logic [1:0] id, input logic [23:0] off,
                                               input bit done, input bit fec);
    vfr_pkg::result_t r;
    r = '0;
    r.accepted = 1'b1;
    r.buffer_id = id;
    r.write_offset = off;
    r.completed = done;
    r.completed_fec = fec;
    return r;
  endfunction

  function automatic logic [10:0] rand_size();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 11'd0;
    if (pick == 1) return 11'd2047;
    return 11'($urandom_range(2047));
  endfunction

  // Next random transaction: mostly in-order parts of a frame stream, with
  // skipped, repeated and abandoned parts, stray headers, releases of the
  // buffers the consumer got, statistics reads and the odd unused action.
  function automatic vfr_pkg::item_t next_stream_item();
    vfr_pkg::item_t it;
    int    roll;
    int    step;
    bit    in_order;
    it = '0;
    in_order = 1'b0;
    roll = $urandom_range(99);
    if (roll < 4) begin
      it.action = vfr_pkg::ACT_STATS;
    end else if (roll < 6) begin
      it = ctl(vfr_pkg::ACT_RELEASE, 2'($urandom_range(3)));
    end else if (roll < 7) begin
      it = hdr($urandom, 16'($urandom), 1'($urandom), 11'($urandom), 1'($urandom));
      it.action = ACT_UNUSED;
      it.release_id = 2'($urandom);
    end else if (roll < 19) begin
      if (finished_buffers.size() > 0)
        it = ctl(vfr_pkg::ACT_RELEASE, finished_buffers.pop_front());
      else in_order = 1'b1;
    end else if (roll < 25) begin
      // Stray header: far away, or a little behind the stream.
      it = hdr(($urandom_range(3) == 0) ? $urandom : gen_frame - $urandom_range(400),
               ($urandom_range(1) == 0) ? 16'($urandom) : gen_part,
               1'($urandom), rand_size(), 1'($urandom));
    end else begin
      in_order = 1'b1;
    end
    if (in_order) begin
      it = hdr(gen_frame, gen_part, gen_part == 16'(gen_total - 1), rand_size(),
               $urandom_range(9) == 0);
      step = $urandom_range(99);
      if (it.is_last || step < 3) begin
        roll = $urandom_range(99);
        if (roll < 8) gen_frame = gen_frame + $urandom_range(2, 6);
        else if (roll < 10) gen_frame = $urandom;
        else gen_frame = gen_frame + 32'd1;
        gen_part = '0;
        gen_total = $urandom_range(1, 6);
      end else if (step < 8) begin
        gen_part = gen_part + 16'd2;
      end else if (step >= 11) begin
        gen_part = gen_part + 16'd1;
      end
    end
    return it;
  endfunction

  // Present one transaction, hold it until it is taken, then queue what the
  // block must answer. A typed row overrides the predicted result.
  task automatic send(input vfr_pkg::item_t it, input bit typed,
                      input vfr_pkg::result_t typed_res);
    vfr_pkg::result_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= it.action;
    in_frame_index     <= it.frame_no;
    in_part_index      <= it.part_no;
    in_last_part       <= it.is_last;
    in_payload_size    <= it.payload_size;
    in_restored_by_fec <= it.restored_by_fec;
    in_release_id      <= it.release_id;
    do @(posedge clk); while (in_stall);
    pred = frame_tracker_step(it);
    pending_results.push_back(typed ? typed_res : pred);
    if (pred.completed) finished_buffers.push_back(pred.buffer_id);
    n_sent++;
  endtask

  // Stop sending and wait until every queued result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write the window register; only called while the block is idle.
  task automatic write_window(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_q = value;
  endtask

  task automatic random_phase(input int items, input int idle, input int stall,
                              input bit mid_pause);
    vfr_pkg::item_t it;
    int    count;
    idle_pct = idle;
    stall_pct = stall;
    count = 0;
    while (count < items) begin
      it = next_stream_item();
      send(it, 1'b0, '0);
      if (it.action != ACT_UNUSED) count++;
      // Let the pipeline run dry in the middle of the phase.
      if (mid_pause && count == items / 2) drain();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, name,
               exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: take every result transaction that is offered and not
  // stalled, check it against the oldest expectation, and pick the next
  // stall value at random.
  always @(posedge clk) begin
    vfr_pkg::result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result transaction with no expectation waiting", $time);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("lost_partial", 64'(exp_r.lost_partial), 64'(out_lost_partial));
        check_field("lost_partial_parts", 64'(exp_r.lost_partial_parts),
                    64'(out_lost_partial_parts));
        check_field("abandoned_next", 64'(exp_r.abandoned_next), 64'(out_abandoned_next));
        check_field("lost_whole_frames", 64'(exp_r.lost_whole_frames),
                    64'(out_lost_whole_frames));
        check_field("accepted", 64'(exp_r.accepted), 64'(out_accepted));
        check_field("buffer_id", 64'(exp_r.buffer_id), 64'(out_buffer_id));
        check_field("write_offset", 64'(exp_r.write_offset), 64'(out_write_offset));
        check_field("completed", 64'(exp_r.completed), 64'(out_completed));
        check_field("completed_fec", 64'(exp_r.completed_fec), 64'(out_completed_fec));
        check_field("discarded_count", 64'(exp_r.discarded_count),
                    64'(out_discarded_count));
        if (exp_r.completed) n_frames_done++;
        n_checked++;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_video_frame_reassembler_unit: FAIL");
      $finish;
    end
  end

  initial begin
    vfr_pkg::item_t it;
    dir_row_t       row;

    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_frames_done = 0;
    cycle_cnt = 0;
    idle_pct = 0;
    stall_pct = 0;

    rst_n              = 1'b0;
    cfg_valid          = 1'b0;
    cfg_data           = '0;
    in_valid           = 1'b0;
    in_action          = vfr_pkg::ACT_HEADER;
    in_frame_index     = '0;
    in_part_index      = '0;
    in_last_part       = 1'b0;
    in_payload_size    = '0;
    in_restored_by_fec = 1'b0;
    in_release_id      = '0;
    out_stall          = 1'b0;

    // Reset state of the tracker copy: all buffers free, highest id on top.
    win_q = vfr_pkg::WINDOW_RESET;
    trk_frame = '0;
    trk_part = '0;
    trk_holding = 1'b0;
    trk_buf = '0;
    trk_discard = 1'b0;
    trk_fec = 1'b0;
    trk_len = '0;
    discard_tot = '0;
    for (int i = 0; i < POOL; i++) free_ids[i] = 2'(i);
    free_n = POOL;

    // Directed table. It starts from reset with the window at 200: a first
    // frame in buffer 2, a repeated part, frames that follow, skip and go
    // backwards across the window, the wrap of the frame index, a pool that
    // runs dry and discards a frame, releases both valid and invalid, and
    // the unused action code.
    dir_rows.push_back('{ctl(vfr_pkg::ACT_STATS, 2'd0), 1'b1, '0});
    dir_rows.push_back('{hdr(32'd0, 16'd0, 1'b0, 11'd2047, 1'b0), 1'b1,
                         acc_res(2'd2, 24'd0, 1'b0, 1'b0)});
    dir_rows.push_back('{hdr(32'd0, 16'd1, 1'b0, 11'd2047, 1'b1), 1'b1,
                         acc_res(2'd2, 24'd2047, 1'b0, 1'b0)});
    dir_rows.push_back('{hdr(32'd0, 16'd1, 1'b0, 11'd2047, 1'b0), 1'b1, '0});
    dir_rows.push_back('{hdr(32'd0, 16'd2, 1'b1, 11'd5, 1'b0), 1'b1,
                         acc_res(2'd2, 24'd4094, 1'b1, 1'b1)});
    dir_rows.push_back('{hdr(32'd1, 16'd0, 1'b0, 11'd0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{hdr(32'd2, 16'd0, 1'b0, 11'd100, 1'b0), 1'b0, '0});
    dir_rows.push_back('{hdr(32'd10, 16'd5, 1'b0, 11'd1, 1'b0), 1'b0, '0});
    dir_rows.push_back('{hdr(32'h8000_0009, 16'd0, 1'b0, 11'd7, 1'b0), 1'b0, '0});
    dir_rows.push_back('{hdr(32'h0000_0010, 16'd0, 1'b0, 11'd9, 1'b0), 1'b0, '0});
    dir_rows.push_back('{hdr(32'hFFFF_FFFF, 16'd0, 1'b0, 11'd3, 1'b1), 1'b0, '0});
    dir_rows.push_back('{hdr(32'd0, 16'd0, 1'b0, 11'd11, 1'b0), 1'b0, '0});
    dir_rows.push_back('{hdr(32'd0, 16'd1, 1'b1, 11'd12, 1'b0), 1'b0, '0});
    dir_rows.push_back('{hdr(32'd1, 16'd0, 1'b1, 11'd2047, 1'b0), 1'b0, '0});
    dir_rows.push_back('{hdr(32'd2, 16'd0, 1'b0, 11'd4, 1'b0), 1'b0, '0});
    dir_rows.push_back('{hdr(32'd2, 16'd0, 1'b0, 11'd4, 1'b0), 1'b0, '0});
    dir_rows.push_back('{ctl(vfr_pkg::ACT_STATS, 2'd0), 1'b0, '0});
    dir_rows.push_back('{ctl(vfr_pkg::ACT_STATS, 2'd0), 1'b0, '0});
    dir_rows.push_back('{ctl(vfr_pkg::ACT_RELEASE, 2'd3), 1'b1, '0});
    dir_rows.push_back('{ctl(vfr_pkg::ACT_RELEASE, 2'd0), 1'b0, '0});
    dir_rows.push_back('{ctl(vfr_pkg::ACT_RELEASE, 2'd1), 1'b0, '0});
    dir_rows.push_back('{ctl(vfr_pkg::ACT_RELEASE, 2'd2), 1'b0, '0});
    dir_rows.push_back('{ctl(vfr_pkg::ACT_RELEASE, 2'd2), 1'b0, '0});
    it = hdr(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 11'd2047, 1'b1);
    it.action = ACT_UNUSED;
    it.release_id = 2'd3;
    dir_rows.push_back('{it, 1'b1, '0});
    dir_rows.push_back('{hdr(32'd3, 16'd0, 1'b1, 11'd0, 1'b1), 1'b0, '0});
    dir_rows.push_back('{ctl(vfr_pkg::ACT_RELEASE, 2'd2), 1'b0, '0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_window(vfr_pkg::WINDOW_RESET);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send(row.it, row.typed, row.res);
    end
    drain();
    // Buffers handed out by the table are not released by the stream.
    finished_buffers.delete();

    gen_frame = trk_frame + 32'd1;
    gen_part = '0;
    gen_total = 3;

    // Random phases: each starts from an idle block with a new window.
    write_window(16'd0);
    random_phase(100, 0, 0, 1'b0);
    drain();
    write_window(16'hFFFF);
    random_phase(100, 65, 0, 1'b0);
    drain();
    write_window(16'd1);
    random_phase(100, 0, 65, 1'b1);
    drain();
    write_window(16'($urandom_range(2, 65534)));
    random_phase(100, 29, 29, 1'b0);
    drain();

    write_window(16'($urandom_range(2, 400)));
    random_phase(100, 29, 29, 1'b0);

    // Wait for the tail of the results, then keep the clock running in case the
    // block sends anything it should not.
    drain();
    repeat (4) @(posedge clk);

    $display("Sent %0d input transactions, checked %0d results, %0d frames completed.",
             n_sent, n_checked, n_frames_done);
    $display("Windows 200, 0, 65535, 1 and random; idle, stall and mixed phases.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_video_frame_reassembler_unit: PASS");
    end else begin
      $display("tb_video_frame_reassembler_unit: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
sv/vfr_pkg.sv
sv/vfr_pool.sv
sv/vfr_core.sv
sv/video_frame_reassembler_unit.sv
sim/tb_video_frame_reassembler_unit.sv
